// File: rtl/core/pmic_i2c_register_file_core_assert.svh
// Assertion macros shared by the register file core.
`ifndef PMIC_I2C_REGISTER_FILE_CORE_ASSERT_SVH
`define PMIC_I2C_REGISTER_FILE_CORE_ASSERT_SVH

// Check that cond implies prop in the same cycle.
`define PMIC_RF_ASSERT_SAME(lbl, clk, rstn, cond, prop) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) (cond) |-> (prop)) \
        else $error("register file core: same-cycle check failed");

// Check that cond implies prop in the next cycle.
`define PMIC_RF_ASSERT_NEXT(lbl, clk, rstn, cond, prop) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) (cond) |=> (prop)) \
        else $error("register file core: next-cycle check failed");

`endif

// File: rtl/core/pmic_rf_pkg.sv
`default_nettype none

package pmic_rf_pkg;

    // Bus request opcodes
    localparam logic [1:0] OP_START = 2'd0;
    localparam logic [1:0] OP_WRITE = 2'd1;
    localparam logic [1:0] OP_READ  = 2'd2;

    // Register addresses with side effects
    localparam logic [7:0] ADDR_PWRCTRL = 8'h01;
    localparam logic [7:0] ADDR_GPO     = 8'h1C;
    localparam logic [7:0] ADDR_TEST    = 8'hFE;

    // Test register unlock
    localparam logic [1:0] UNLOCK_LAST  = 2'd2;
    localparam logic [1:0] UNLOCK_DONE  = 2'd3;
    localparam logic [7:0] TEST_OPEN    = 8'hFF;
    localparam logic [7:0] TEST_CLOSED  = 8'h00;
    localparam logic [1:0] PWR_OFF_MASK = 2'b11;

    typedef struct packed {
        logic [1:0] opcode;
        logic [7:0] data_byte;
    } req_t;

    typedef struct packed {
        logic [7:0] read_data;
        logic [3:0] gpo_levels;
        logic       shutdown_request;
    } rsp_t;

    typedef struct packed {
        logic       wr_en;
        logic       rd_en;
        logic [7:0] addr;
        logic [7:0] wdata;
    } mem_cmd_t;

    // Expected byte at each unlock step
    function automatic logic [7:0] unlock_byte(input logic [1:0] step);
        logic [7:0] b;
        case (step)
            2'd0:    b = 8'h76;
            2'd1:    b = 8'h66;
            2'd2:    b = 8'h56;
            default: b = 8'h00;
        endcase
        return b;
    endfunction

    // Power-on contents of the register bank
    function automatic logic [7:0] reg_default(input logic [7:0] addr);
        logic [7:0] v;
        case (addr)
            8'h00:   v = 8'h15;
            8'h37:   v = 8'h03;
            8'h3B:   v = 8'h30;
            8'h5F:   v = 8'hAF;
            8'h5D, 8'h67, 8'h6B, 8'h6D, 8'hC0, 8'hC2,
            8'hD4, 8'hD6, 8'hD8, 8'hDA:
                     v = 8'h0F;
            8'h5E, 8'h68, 8'h6C, 8'h6E, 8'hC1, 8'hC3:
                     v = 8'hA0;
            8'hD5, 8'hD9:
                     v = 8'h6E;
            8'hD7, 8'hDB:
                     v = 8'hD2;
            8'h79:   v = 8'h02;
            8'h7A:   v = 8'hD8;
            8'hE8:   v = 8'h03;
            8'hE9:   v = 8'h8E;
            default: v = 8'h00;
        endcase
        return v;
    endfunction

endpackage

`default_nettype wire

// File: rtl/core/pmic_rf_bank.sv
`default_nettype none

module pmic_rf_bank (
    input  wire logic                 aclk,
    input  wire logic                 aresetn,
    input  wire pmic_rf_pkg::mem_cmd_t cmd,
    output logic [7:0]                rdata
);

    logic [7:0] mem [256];
    logic [255:0] written_reg;
    logic [7:0] mem_q_reg;
    logic       hit_q_reg;
    logic [7:0] dflt_q_reg;

    // Store bytes; no reset on the array itself
    always_ff @(posedge aclk) begin
        if (cmd.wr_en) begin
            mem[cmd.addr] <= cmd.wdata;
        end
    end

    // Track which entries were written since reset
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            written_reg <= '0;
        end else if (cmd.wr_en) begin
            written_reg[cmd.addr] <= 1'b1;
        end
    end

    // Register read data along with the power-on value of the entry
    always_ff @(posedge aclk) begin
        if (cmd.rd_en) begin
            mem_q_reg  <= mem[cmd.addr];
            hit_q_reg  <= written_reg[cmd.addr];
            dflt_q_reg <= pmic_rf_pkg::reg_default(cmd.addr);
        end
    end

    assign rdata = hit_q_reg ? mem_q_reg : dflt_q_reg;

endmodule

`default_nettype wire

// File: rtl/core/pmic_rf_seq.sv
`default_nettype none

module pmic_rf_seq #(
    parameter int GPO_PINS = 4
) (
    input  wire logic                  aclk,
    input  wire logic                  aresetn,
    input  wire logic                  accept,
    input  wire pmic_rf_pkg::req_t     req,
    output pmic_rf_pkg::mem_cmd_t      cmd,
    output logic [3:0]                 gpo_levels,
    output logic                       shutdown
);

    localparam int GpoBits = (GPO_PINS < 4) ? GPO_PINS : 4;
    localparam logic [3:0] GpoMask = 4'((1 << GpoBits) - 1);

    logic [7:0] ptr_reg, ptr_next;
    logic       loaded_reg, loaded_next;
    logic [1:0] step_reg, step_next;
    logic [3:0] gpo_reg, gpo_next;
    logic       wr, rd, shut;
    logic [7:0] wdata;

    // Decode one request against the pointer and unlock state
    always_comb begin
        ptr_next    = ptr_reg;
        loaded_next = loaded_reg;
        step_next   = step_reg;
        gpo_next    = gpo_reg;
        wr          = 1'b0;
        rd          = 1'b0;
        shut        = 1'b0;
        wdata       = req.data_byte;
        case (req.opcode)
            pmic_rf_pkg::OP_START: begin
                loaded_next = 1'b0;
            end
            pmic_rf_pkg::OP_WRITE: begin
                if (!loaded_reg) begin
                    loaded_next = 1'b1;
                    ptr_next    = req.data_byte;
                end else begin
                    if (ptr_reg == pmic_rf_pkg::ADDR_TEST) begin
                        if (req.data_byte == pmic_rf_pkg::TEST_CLOSED) begin
                            step_next = '0;
                            wr        = 1'b1;
                            wdata     = pmic_rf_pkg::TEST_CLOSED;
                        end else if (step_reg != pmic_rf_pkg::UNLOCK_DONE &&
                                     req.data_byte == pmic_rf_pkg::unlock_byte(step_reg)) begin
                            step_next = step_reg + 2'd1;
                            if (step_reg == pmic_rf_pkg::UNLOCK_LAST) begin
                                wr    = 1'b1;
                                wdata = pmic_rf_pkg::TEST_OPEN;
                            end
                        end else begin
                            step_next = '0;
                        end
                    end else begin
                        wr = 1'b1;
                        if (ptr_reg == pmic_rf_pkg::ADDR_PWRCTRL &&
                            (req.data_byte[1:0] & pmic_rf_pkg::PWR_OFF_MASK) != 2'b00) begin
                            shut = 1'b1;
                        end
                        if (ptr_reg == pmic_rf_pkg::ADDR_GPO) begin
                            gpo_next = req.data_byte[3:0] & GpoMask;
                        end
                    end
                    ptr_next = ptr_reg + 8'd1;
                end
            end
            pmic_rf_pkg::OP_READ: begin
                rd       = 1'b1;
                ptr_next = ptr_reg + 8'd1;
            end
            default: begin
            end
        endcase
    end

    // Advance state only on an accepted request
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            ptr_reg    <= '0;
            loaded_reg <= 1'b0;
            step_reg   <= '0;
            gpo_reg    <= '0;
        end else if (accept) begin
            ptr_reg    <= ptr_next;
            loaded_reg <= loaded_next;
            step_reg   <= step_next;
            gpo_reg    <= gpo_next;
        end
    end

    assign cmd.wr_en  = wr & accept;
    assign cmd.rd_en  = rd & accept;
    assign cmd.addr   = ptr_reg;
    assign cmd.wdata  = wdata;
    assign gpo_levels = gpo_next;
    assign shutdown   = shut;

endmodule

`default_nettype wire

// File: rtl/core/pmic_i2c_register_file_core.sv
// Register side of a power management chip, driven one bus byte at a time.
// Input channel s_*: one request per accepted item; opcode start-of-write,
// write byte or read byte, with the data byte for writes.
// Result channel m_*: exactly one result per request, in order: read data
// (zero unless a read), the general purpose output levels after the request,
// and a shutdown flag for a power control write with a low bit set.
// Path: each request passes the register bank access stage, then the
// output register.
// Throughput: one request per cycle while m_ready is high; the pointer,
// unlock state and bank write all settle in the acceptance cycle, so a
// read right after a write sees the new byte.
// Reset: aresetn low for one cycle empties the pipeline, zeroes the pointer
// and unlock state and returns every register to its power-on value; the
// core accepts requests in the first cycle after reset.
// Stall: while m_ready is low the result holds; one more request may be
// taken into the internal stage, after which s_ready drops.
`default_nettype none

`include "pmic_i2c_register_file_core_assert.svh"

module pmic_i2c_register_file_core #(
    parameter int GPO_PINS = 4
) (
    input  wire logic               aclk,
    input  wire logic               aresetn,
    input  wire logic               s_valid,
    output logic                    s_ready,
    input  wire pmic_rf_pkg::req_t  s_req,
    output logic                    m_valid,
    input  wire logic               m_ready,
    output pmic_rf_pkg::rsp_t       m_rsp
);

    pmic_rf_pkg::mem_cmd_t cmd;
    logic [7:0] bank_rdata;
    logic [3:0] gpo_now;
    logic       shut_now;
    logic       accept, advance;

    logic       s1_valid_reg;
    logic       s1_read_reg;
    logic [3:0] s1_gpo_reg;
    logic       s1_shut_reg;
    logic       m_valid_reg;
    pmic_rf_pkg::rsp_t m_rsp_reg;

    assign advance = s1_valid_reg & (~m_valid_reg | m_ready);
    assign s_ready = ~s1_valid_reg | ~m_valid_reg | m_ready;
    assign accept  = s_valid & s_ready;

    pmic_rf_seq #(
        .GPO_PINS (GPO_PINS)
    ) u_seq (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .accept     (accept),
        .req        (s_req),
        .cmd        (cmd),
        .gpo_levels (gpo_now),
        .shutdown   (shut_now)
    );

    pmic_rf_bank u_bank (
        .aclk    (aclk),
        .aresetn (aresetn),
        .cmd     (cmd),
        .rdata   (bank_rdata)
    );

    // Hold the access stage until the output register takes it
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            s1_valid_reg <= 1'b0;
        end else if (accept) begin
            s1_valid_reg <= 1'b1;
        end else if (advance) begin
            s1_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (accept) begin
            s1_read_reg <= (s_req.opcode == pmic_rf_pkg::OP_READ);
            s1_gpo_reg  <= gpo_now;
            s1_shut_reg <= shut_now;
        end
    end

    // Output register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else if (advance) begin
            m_valid_reg <= 1'b1;
        end else if (m_ready) begin
            m_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (advance) begin
            m_rsp_reg.read_data        <= s1_read_reg ? bank_rdata : 8'h00;
            m_rsp_reg.gpo_levels       <= s1_gpo_reg;
            m_rsp_reg.shutdown_request <= s1_shut_reg;
        end
    end

    assign m_valid = m_valid_reg;
    assign m_rsp   = m_rsp_reg;

    // Pipeline and decode checks
    `PMIC_RF_ASSERT_NEXT(a_stage_held, aclk, aresetn,
        s1_valid_reg && m_valid_reg && !m_ready, s1_valid_reg)
    `PMIC_RF_ASSERT_SAME(a_ready_when_out_free, aclk, aresetn,
        !m_valid_reg, s_ready)
    `PMIC_RF_ASSERT_NEXT(a_shut_only_on_write, aclk, aresetn,
        accept && s_req.opcode != pmic_rf_pkg::OP_WRITE, !s1_shut_reg)

endmodule

`default_nettype wire
